// File: rtl/sbfs_pkg.sv
`default_nettype none

package sbfs_pkg;

    localparam int STUFF_INTERVAL = 4;
    localparam int POS_W          = $clog2(STUFF_INTERVAL);

    localparam int PAYLOAD_W = 32;
    localparam int CHAR_W    = 8;
    localparam int SHIFT_W   = PAYLOAD_W + 2;
    localparam int CNT_W     = $clog2(SHIFT_W + 1);

    localparam int S_TDATA_W = ((2 + PAYLOAD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    localparam int CONNECT_BITS = 6;
    localparam int CHAR_BITS    = CHAR_W + 2;
    localparam int INT_BITS     = PAYLOAD_W + 2;
    localparam int CLEAR_BITS   = 2;

    typedef enum logic [1:0] {
        OP_CONNECT = 2'd0,
        OP_CHAR    = 2'd1,
        OP_INT     = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic step;
    } sbfs_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic final_bit;
    } sbfs_status_t;

endpackage

`default_nettype wire

// File: rtl/stuffed_bit_frame_serializer_unit.sv
`default_nettype none

// Channel   Direction  Ports                                 Content
// input     slave      s_tvalid, s_tready, s_tdata           one command per transfer
// result    master     m_tvalid, m_tready, m_tdata, m_tlast  one line bit per transfer
//
// A command is taken, then one line bit is produced per cycle while the
// result register is free: 6 bits for connect, 2 to 3 for clear, up to 13 for char and
// up to 43 for int, set by the single bit shifter that feeds the result register.
// A stalled result channel holds the bit shifter; a new command is taken only after the
// last bit of the previous one is in the result register. Reset clears the bit position.

module stuffed_bit_frame_serializer_unit
    import sbfs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // op[1:0], payload[33:2], zero fill
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // line_bit[0], stuffed[1], zero fill
    output logic                      m_tlast
);

    sbfs_cmd_t    cmd;
    sbfs_status_t status;
    logic         line_bit, stuffed;

    sbfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sbfs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (s_tdata[1:0]),
        .payload  (s_tdata[PAYLOAD_W+1:2]),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .line_bit (line_bit),
        .stuffed  (stuffed),
        .last     (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W-2){1'b0}}, stuffed, line_bit};

endmodule

`default_nettype wire

// File: rtl/sbfs_ctrl.sv
`default_nettype none

module sbfs_ctrl
    import sbfs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire sbfs_status_t status,
    output sbfs_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.slot_free) begin
                    cmd.step = 1'b1;
                    if (status.final_bit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sbfs_dp.sv
`default_nettype none

module sbfs_dp
    import sbfs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [1:0]           op,
    input  wire logic [PAYLOAD_W-1:0] payload,
    input  wire sbfs_cmd_t            cmd,
    output sbfs_status_t              status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic                      line_bit,
    output logic                      stuffed,
    output logic                      last
);

    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               counted_reg, counted_next;
    logic               stuff_pend_reg, stuff_pend_next;
    logic               m_valid_reg;
    logic               bit_reg, stuffed_reg, last_reg;
    logic               emit_bit, emit_stuffed, pos_wrap;

    assign pos_wrap = counted_reg && (pos_reg == POS_W'(STUFF_INTERVAL - 1));

    always_comb begin
        status.slot_free = !m_valid_reg || m_tready;
        if (stuff_pend_reg) begin
            status.final_bit = (remain_reg == '0);
        end else begin
            status.final_bit = (remain_reg == CNT_W'(1)) && !pos_wrap;
        end
    end

    always_comb begin
        shift_next      = shift_reg;
        remain_next     = remain_reg;
        pos_next        = pos_reg;
        counted_next    = counted_reg;
        stuff_pend_next = stuff_pend_reg;
        emit_bit        = shift_reg[SHIFT_W-1];
        emit_stuffed    = 1'b0;
        if (cmd.load) begin
            stuff_pend_next = 1'b0;
            counted_next    = 1'b1;
            case (op_t'(op))
                OP_CONNECT: begin
                    shift_next   = {1'b1, {(SHIFT_W-1){1'b0}}};
                    remain_next  = CNT_W'(CONNECT_BITS);
                    counted_next = 1'b0;
                    pos_next     = '0;
                end
                OP_CHAR: begin
                    shift_next  = {2'b10, payload[CHAR_W-1:0], {(PAYLOAD_W-CHAR_W){1'b0}}};
                    remain_next = CNT_W'(CHAR_BITS);
                end
                OP_INT: begin
                    shift_next  = {2'b01, payload};
                    remain_next = CNT_W'(INT_BITS);
                end
                OP_CLEAR: begin
                    shift_next  = '0;
                    remain_next = CNT_W'(CLEAR_BITS);
                end
                default: begin
                    shift_next  = '0;
                    remain_next = '0;
                end
            endcase
        end else if (cmd.step) begin
            if (stuff_pend_reg) begin
                emit_bit        = 1'b1;
                emit_stuffed    = 1'b1;
                stuff_pend_next = 1'b0;
                pos_next        = '0;
            end else begin
                shift_next  = {shift_reg[SHIFT_W-2:0], 1'b0};
                remain_next = remain_reg - CNT_W'(1);
                if (counted_reg) begin
                    if (pos_wrap) begin
                        stuff_pend_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            stuff_pend_reg <= 1'b0;
            remain_reg     <= '0;
            counted_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            stuff_pend_reg <= stuff_pend_next;
            remain_reg     <= remain_next;
            counted_reg    <= counted_next;
            if (cmd.step) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (cmd.step) begin
            bit_reg     <= emit_bit;
            stuffed_reg <= emit_stuffed;
            last_reg    <= status.final_bit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign line_bit = bit_reg;
    assign stuffed  = stuffed_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire
